@@ design/eur_pkg.sv @@
// ----------------------------------------------------------------------------
// eur_pkg
// Types, widths and constants shared by the Euler rotation pipeline.
// ----------------------------------------------------------------------------
package eur_pkg;

  localparam int COORD_W       = 32;
  localparam int ANGLE_W       = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ANGLE_FRAC  = ANGLE_W - 3;
  localparam int ANG_SHIFT   = 30 - ANGLE_FRAC;
  // angle in units of 2^-30 rad, wide enough for the raw value and a 2*pi fold
  localparam int ANG_W       = ANGLE_W + ANG_SHIFT + 2;
  localparam int TRIG_W      = 33;
  localparam int CRD_W       = COORD_W + 4;
  localparam int PROD_W      = CRD_W + TRIG_W;
  localparam int STG_W       = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int ATAN_IDX_W  = 5;
  localparam int NUM_LANES   = 3;

  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd3373259426);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1686629713);
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = ANG_W'(64'sd6746518852);
  localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(64'sd652032874);

  // lane order inside the CORDIC chain
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [ANGLE_W-1:0] angle_about_x;
    logic signed [ANGLE_W-1:0] angle_about_y;
    logic signed [ANGLE_W-1:0] angle_about_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [ANG_W-1:0]  a;
    logic                     neg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    point_t                pt;
  } cordic_t;

  // data riding alongside one plane rotation
  typedef struct packed {
    logic signed [CRD_W-1:0]  crd;
    logic signed [TRIG_W-1:0] sin_a;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_b;
    logic signed [TRIG_W-1:0] cos_b;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = ANG_W'(64'sd843314857);
      5'd1:    r = ANG_W'(64'sd497837829);
      5'd2:    r = ANG_W'(64'sd263043837);
      5'd3:    r = ANG_W'(64'sd133525159);
      5'd4:    r = ANG_W'(64'sd67021687);
      5'd5:    r = ANG_W'(64'sd33543516);
      5'd6:    r = ANG_W'(64'sd16775851);
      5'd7:    r = ANG_W'(64'sd8388437);
      5'd8:    r = ANG_W'(64'sd4194283);
      5'd9:    r = ANG_W'(64'sd2097149);
      5'd10:   r = ANG_W'(64'sd1048576);
      5'd11:   r = ANG_W'(64'sd524288);
      5'd12:   r = ANG_W'(64'sd262144);
      5'd13:   r = ANG_W'(64'sd131072);
      5'd14:   r = ANG_W'(64'sd65536);
      5'd15:   r = ANG_W'(64'sd32768);
      5'd16:   r = ANG_W'(64'sd16384);
      5'd17:   r = ANG_W'(64'sd8192);
      5'd18:   r = ANG_W'(64'sd4096);
      5'd19:   r = ANG_W'(64'sd2048);
      5'd20:   r = ANG_W'(64'sd1024);
      5'd21:   r = ANG_W'(64'sd512);
      5'd22:   r = ANG_W'(64'sd256);
      5'd23:   r = ANG_W'(64'sd128);
      5'd24:   r = ANG_W'(64'sd64);
      5'd25:   r = ANG_W'(64'sd32);
      5'd26:   r = ANG_W'(64'sd16);
      5'd27:   r = ANG_W'(64'sd8);
      5'd28:   r = ANG_W'(64'sd4);
      5'd29:   r = ANG_W'(64'sd2);
      5'd30:   r = ANG_W'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/eur_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// eur_cordic_cell
// One CORDIC micro-rotation for the three angle lanes, registered.
// ----------------------------------------------------------------------------
module eur_cordic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [eur_pkg::STG_W-1:0] stage_i,
  input  logic                      valid_i,
  input  eur_pkg::cordic_t          data_i,
  output logic                      valid_o,
  output eur_pkg::cordic_t          data_o
);
  import eur_pkg::*;

  cordic_t                 data_d, data_q;
  logic                    valid_q;
  logic signed [ANG_W-1:0] atan_val;

  assign atan_val = atan_lut(ATAN_IDX_W'(stage_i));

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (!data_i.lane[l].a[ANG_W-1]) begin
        data_d.lane[l].x = data_i.lane[l].x - (data_i.lane[l].y >>> stage_i);
        data_d.lane[l].y = data_i.lane[l].y + (data_i.lane[l].x >>> stage_i);
        data_d.lane[l].a = data_i.lane[l].a - atan_val;
      end else begin
        data_d.lane[l].x = data_i.lane[l].x + (data_i.lane[l].y >>> stage_i);
        data_d.lane[l].y = data_i.lane[l].y - (data_i.lane[l].x >>> stage_i);
        data_d.lane[l].a = data_i.lane[l].a + atan_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/eur_rot_cell.sv @@
// ----------------------------------------------------------------------------
// eur_rot_cell
// One plane rotation: four rounded Q30 products, then the two sums.
// p = a*cos - b*sin, q = a*sin + b*cos. Two register stages.
// ----------------------------------------------------------------------------
module eur_rot_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [eur_pkg::CRD_W-1:0]  a_i,
  input  logic signed [eur_pkg::CRD_W-1:0]  b_i,
  input  logic signed [eur_pkg::TRIG_W-1:0] sin_i,
  input  logic signed [eur_pkg::TRIG_W-1:0] cos_i,
  input  eur_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [eur_pkg::CRD_W-1:0]  p_o,
  output logic signed [eur_pkg::CRD_W-1:0]  q_o,
  output eur_pkg::side_t                    side_o
);
  import eur_pkg::*;

  localparam logic signed [PROD_W-1:0] RND = PROD_W'(64'sd536870912);

  logic signed [PROD_W-1:0] ac, bs, as_, bc;
  logic signed [CRD_W-1:0]  ac_q, bs_q, as_q, bc_q;
  logic signed [CRD_W-1:0]  p_q, q_q;
  side_t                    side1_q, side2_q;
  logic                     v1_q, v2_q;

  function automatic logic signed [CRD_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND) >>> 30;
    return t[CRD_W-1:0];
  endfunction

  assign ac  = a_i * cos_i;
  assign bs  = b_i * sin_i;
  assign as_ = a_i * sin_i;
  assign bc  = b_i * cos_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q    <= rnd_q30(ac);
      bs_q    <= rnd_q30(bs);
      as_q    <= rnd_q30(as_);
      bc_q    <= rnd_q30(bc);
      side1_q <= side_i;
      p_q     <= ac_q - bs_q;
      q_q     <= as_q + bc_q;
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign side_o  = side2_q;

endmodule

@@ design/euler_rotate_3d_point.sv @@
// ----------------------------------------------------------------------------
// euler_rotate_3d_point
// Rotates a Q16.16 point about z, then x, then y, with CORDIC sine/cosine.
// ----------------------------------------------------------------------------
//  channel | signals                            | payload
//  in      | in_valid_i / in_ready_o            | in_data_i  (eur_pkg::in_item_t)
//  out     | out_valid_o / out_ready_i          | out_data_o (eur_pkg::out_item_t)
//
//  One item per cycle while the output does not stall. The pipeline holds the
//  angle fold stages, the chain of CORDIC cells and three two-stage rotation cells.
//  The whole pipeline advances together whenever the output register is
//  empty or being taken; a stalled output freezes every stage.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module euler_rotate_3d_point (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eur_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eur_pkg::out_item_t out_data_o
);
  import eur_pkg::*;

  localparam logic signed [CRD_W-1:0] SAT_HI = CRD_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [CRD_W-1:0] SAT_LO = -SAT_HI - CRD_W'(1);

  logic en;

  // angle fold stages
  cordic_t p1_d, p1_q, p2_d, p2_q;
  logic    p1_vq, p2_vq;

  logic [ANGLE_W-1:0] raw_ang [NUM_LANES];

  assign raw_ang[LANE_X] = in_data_i.angle_about_x;
  assign raw_ang[LANE_Y] = in_data_i.angle_about_y;
  assign raw_ang[LANE_Z] = in_data_i.angle_about_z;

  always_comb begin
    logic signed [ANG_W-1:0] w;
    p1_d.pt.x = in_data_i.point_x;
    p1_d.pt.y = in_data_i.point_y;
    p1_d.pt.z = in_data_i.point_z;
    for (int l = 0; l < NUM_LANES; l++) begin
      w = ANG_W'(signed'(raw_ang[l])) <<< ANG_SHIFT;
      if (w > ANG_PI) begin
        w = w - ANG_TWO_PI;
      end else if (w < -ANG_PI) begin
        w = w + ANG_TWO_PI;
      end
      p1_d.lane[l].a   = w;
      p1_d.lane[l].x   = CORDIC_START;
      p1_d.lane[l].y   = '0;
      p1_d.lane[l].neg = 1'b0;
    end
  end

  always_comb begin
    p2_d = p1_q;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (p1_q.lane[l].a > ANG_HALF_PI) begin
        p2_d.lane[l].a   = p1_q.lane[l].a - ANG_PI;
        p2_d.lane[l].neg = 1'b1;
      end else if (p1_q.lane[l].a < -ANG_HALF_PI) begin
        p2_d.lane[l].a   = p1_q.lane[l].a + ANG_PI;
        p2_d.lane[l].neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vq <= 1'b0;
      p2_vq <= 1'b0;
    end else if (en) begin
      p1_vq <= in_valid_i;
      p2_vq <= p1_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // CORDIC chain
  cordic_t cd [CORDIC_STAGES+1];
  logic    cv [CORDIC_STAGES+1];

  assign cd[0] = p2_q;
  assign cv[0] = p2_vq;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    eur_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (STG_W'(g)),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // quadrant correction of sine and cosine
  logic signed [TRIG_W-1:0] sin_q [NUM_LANES];
  logic signed [TRIG_W-1:0] cos_q [NUM_LANES];
  point_t                   tpt_q;
  logic                     tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (en) begin
      tv_q <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tpt_q <= cd[CORDIC_STAGES].pt;
      for (int l = 0; l < NUM_LANES; l++) begin
        if (cd[CORDIC_STAGES].lane[l].neg) begin
          sin_q[l] <= -cd[CORDIC_STAGES].lane[l].y;
          cos_q[l] <= -cd[CORDIC_STAGES].lane[l].x;
        end else begin
          sin_q[l] <= cd[CORDIC_STAGES].lane[l].y;
          cos_q[l] <= cd[CORDIC_STAGES].lane[l].x;
        end
      end
    end
  end

  // rotation about z
  side_t                   sz_in, sz_out, sx_in, sx_out, sy_in, sy_out;
  logic signed [CRD_W-1:0] x1, y1, y2, z2, z3, x3;
  logic                    vz, vx, vy;

  assign sz_in.crd   = CRD_W'(tpt_q.z);
  assign sz_in.sin_a = sin_q[LANE_X];
  assign sz_in.cos_a = cos_q[LANE_X];
  assign sz_in.sin_b = sin_q[LANE_Y];
  assign sz_in.cos_b = cos_q[LANE_Y];

  eur_rot_cell u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv_q),
    .a_i     (CRD_W'(tpt_q.x)),
    .b_i     (CRD_W'(tpt_q.y)),
    .sin_i   (sin_q[LANE_Z]),
    .cos_i   (cos_q[LANE_Z]),
    .side_i  (sz_in),
    .valid_o (vz),
    .p_o     (x1),
    .q_o     (y1),
    .side_o  (sz_out)
  );

  // rotation about x: a = y1, b = z
  assign sx_in.crd   = x1;
  assign sx_in.sin_a = sz_out.sin_b;
  assign sx_in.cos_a = sz_out.cos_b;
  assign sx_in.sin_b = '0;
  assign sx_in.cos_b = '0;

  eur_rot_cell u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vz),
    .a_i     (y1),
    .b_i     (sz_out.crd),
    .sin_i   (sz_out.sin_a),
    .cos_i   (sz_out.cos_a),
    .side_i  (sx_in),
    .valid_o (vx),
    .p_o     (y2),
    .q_o     (z2),
    .side_o  (sx_out)
  );

  // rotation about y: a = z2, b = x1
  assign sy_in.crd   = y2;
  assign sy_in.sin_a = '0;
  assign sy_in.cos_a = '0;
  assign sy_in.sin_b = '0;
  assign sy_in.cos_b = '0;

  eur_rot_cell u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vx),
    .a_i     (z2),
    .b_i     (sx_out.crd),
    .sin_i   (sx_out.sin_a),
    .cos_i   (sx_out.cos_a),
    .side_i  (sy_in),
    .valid_o (vy),
    .p_o     (z3),
    .q_o     (x3),
    .side_o  (sy_out)
  );

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [CRD_W-1:0] v);
    logic signed [CRD_W-1:0] t;
    t = v;
    if (v > SAT_HI) begin
      t = SAT_HI;
    end else if (v < SAT_LO) begin
      t = SAT_LO;
    end
    return t[COORD_W-1:0];
  endfunction

  // output register
  out_item_t out_q;
  logic      out_vq;

  assign en = !out_vq || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (en) begin
      out_vq <= vy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.rotated_x <= sat(x3);
      out_q.rotated_y <= sat(sy_out.crd);
      out_q.rotated_z <= sat(z3);
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

  // pipeline only halts on a stalled, full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("pipeline halted without output backpressure");

  // an accepted item lands in the first fold stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> p1_vq)
    else $error("accepted item lost at pipeline entry");

  // a stalled output keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_q)))
    else $error("output item changed while stalled");

endmodule
